>>> design/csps_pkg.sv
package csps_pkg;

  localparam int POS_W       = 15;
  localparam int REV_W       = 16;
  localparam int WID_W       = 16;
  localparam int DIAG_W      = 8;
  localparam int VAL_W       = 2;
  localparam int LVL_W       = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int CSPS_QUEUE_DEPTH = 2;

  // item kinds
  localparam logic CMD_EDGE  = 1'b0;
  localparam logic CMD_CRANK = 1'b1;

  // pin level codes
  localparam logic [LVL_W-1:0] LVL_LOW  = 2'd0;
  localparam logic [LVL_W-1:0] LVL_HIGH = 2'd1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_MIN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_MAX      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_MIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_MAX    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DESYNC_ERR   = 3'd5;

  // cam validity codes
  localparam logic [VAL_W-1:0] VAL_NONE     = 2'd0;
  localparam logic [VAL_W-1:0] VAL_DETECTED = 2'd1;
  localparam logic [VAL_W-1:0] VAL_SYNCED   = 2'd2;
  localparam logic [VAL_W-1:0] VAL_VALID    = 2'd3;

  // diag flag bit positions
  localparam int DIAG_SEQUENCE  = 0;
  localparam int DIAG_CRANK_ERR = 1;
  localparam int DIAG_WRONG     = 2;
  localparam int DIAG_WIDTH     = 3;
  localparam int DIAG_EXTRA     = 4;
  localparam int DIAG_BAD_PULSE = 5;
  localparam int DIAG_LOST      = 6;
  localparam int DIAG_NONE      = 7;

  // reset values of the configuration registers
  localparam logic [POS_W-1:0] WIN_MAX_RST   = 15'd23039;
  localparam logic [WID_W-1:0] WIDTH_MAX_RST = 16'd23039;

  typedef struct packed {
    logic             cmd;
    logic [LVL_W-1:0] pin_level;
    logic             crank_valid;
    logic             crank_error;
    logic [POS_W-1:0] crank_position;
    logic [POS_W-1:0] crank_prev_position;
    logic [REV_W-1:0] revolutions;
  } csps_in_t;

  typedef struct packed {
    logic [VAL_W-1:0]  cam_validity;
    logic [POS_W-1:0]  cam_position;
    logic [DIAG_W-1:0] diag_flags;
  } csps_out_t;

  typedef struct packed {
    logic             active_low;
    logic [POS_W-1:0] edge_window_min;
    logic [POS_W-1:0] edge_window_max;
    logic [WID_W-1:0] width_min;
    logic [WID_W-1:0] width_max;
    logic             desync_err;
  } csps_cfg_t;

  // classified item handed from front to back
  typedef struct packed {
    logic             is_crank;
    logic             lvl_undef;
    logic             lvl_high;
    logic             crank_valid;
    logic             crank_error;
    logic [POS_W-1:0] pos;
    logic             in_window;
    logic             above_max;
    logic             wrap;
    logic             rev_odd;
    logic             rev_ge2;
  } csps_item_t;

endpackage

>>> design/csps_front.sv
module csps_front import csps_pkg::*; (
  input  csps_in_t   in_data,
  input  csps_cfg_t  cfg,
  output csps_item_t item
);

  always_comb begin
    item.is_crank    = (in_data.cmd == CMD_CRANK);
    // codes 2 and 3 both count as undefined
    item.lvl_undef   = (in_data.pin_level != LVL_LOW) && (in_data.pin_level != LVL_HIGH);
    item.lvl_high    = (in_data.pin_level == LVL_HIGH);
    item.crank_valid = in_data.crank_valid;
    item.crank_error = in_data.crank_error;
    item.pos         = in_data.crank_position;
    item.in_window   = (in_data.crank_position >= cfg.edge_window_min) &&
                       (in_data.crank_position <= cfg.edge_window_max);
    item.above_max   = (in_data.crank_position > cfg.edge_window_max);
    item.wrap        = (in_data.crank_position < in_data.crank_prev_position);
    item.rev_odd     = in_data.revolutions[0];
    item.rev_ge2     = (in_data.revolutions[REV_W-1:1] != '0);
  end

endmodule

>>> design/csps_queue.sv
module csps_queue import csps_pkg::*; #(
  parameter int DEPTH = CSPS_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  output logic       push_ready,
  input  csps_item_t push_data,
  output logic       pop_valid,
  input  logic       pop_ready,
  output csps_item_t pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  csps_item_t mem [DEPTH];

  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          push, pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> design/csps_back.sv
module csps_back import csps_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  csps_cfg_t  cfg,
  input  logic       item_valid,
  output logic       item_ready,
  input  csps_item_t item,
  output logic       out_valid,
  input  logic       out_ready,
  output csps_out_t  out_data
);

  logic [1:0]        prev_idx_r, prev_idx_nxt;
  logic              next_idx_r, next_idx_nxt;
  logic [POS_W-1:0]  first_pos_r, first_pos_nxt;
  logic [POS_W-1:0]  second_pos_r, second_pos_nxt;
  logic              first_found_r, first_found_nxt;
  logic              phase_synced_r, phase_synced_nxt;
  logic              odd_rev_r, odd_rev_nxt;
  logic              crank_synced_r, crank_synced_nxt;
  logic              found_r, found_nxt;
  logic [VAL_W-1:0]  held_val_r, held_val_nxt;
  logic [POS_W-1:0]  held_pos_r, held_pos_nxt;
  logic [DIAG_W-1:0] diag_r, diag_nxt;
  logic              out_valid_r, out_valid_nxt;
  csps_out_t         out_data_r, out_data_nxt;

  logic               take;
  logic [1:0]         idx;
  logic               exp_high;
  logic               desync;
  logic               clean;
  logic [VAL_W-1:0]   val;
  logic [POS_W-1:0]   mid;
  logic [DIAG_W-1:0]  diag_set;
  logic signed [16:0] width;
  logic signed [16:0] wmin, wmax;
  logic [POS_W:0]     mid_sum;

  assign item_ready = !out_valid_r || out_ready;
  assign take       = item_valid && item_ready;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  assign wmin = $signed({cfg.width_min[WID_W-1], cfg.width_min});
  assign wmax = $signed({cfg.width_max[WID_W-1], cfg.width_max});

  always_comb begin
    prev_idx_nxt     = prev_idx_r;
    next_idx_nxt     = next_idx_r;
    first_pos_nxt    = first_pos_r;
    second_pos_nxt   = second_pos_r;
    first_found_nxt  = first_found_r;
    phase_synced_nxt = phase_synced_r;
    odd_rev_nxt      = odd_rev_r;
    crank_synced_nxt = crank_synced_r;
    found_nxt        = found_r;
    held_val_nxt     = held_val_r;
    held_pos_nxt     = held_pos_r;
    idx              = item.lvl_undef ? {1'b0, next_idx_r} : {1'b0, item.lvl_high};
    exp_high         = first_found_r ? cfg.active_low : ~cfg.active_low;
    desync           = 1'b0;
    clean            = 1'b0;
    val              = held_val_r;
    mid              = held_pos_r;
    diag_set         = '0;
    width            = '0;
    mid_sum          = '0;

    if (take) begin
      if (!item.is_crank) begin
        if (idx == prev_idx_r) begin
          diag_set[DIAG_SEQUENCE] = 1'b1;
        end else begin
          if (item.lvl_undef || (item.lvl_high == exp_high)) begin
            if (item.crank_error) begin
              diag_set[DIAG_CRANK_ERR] = 1'b1;
              desync = 1'b1;
            end
            if (item.crank_valid) begin
              if (item.in_window) begin
                if (!first_found_r) begin
                  val             = VAL_DETECTED;
                  first_pos_nxt   = item.pos;
                  first_found_nxt = 1'b1;
                end else begin
                  first_found_nxt  = 1'b0;
                  val              = VAL_SYNCED;
                  second_pos_nxt   = item.pos;
                  crank_synced_nxt = 1'b1;
                end
              end else begin
                if (crank_synced_r) begin
                  diag_set[DIAG_WRONG] = 1'b1;
                  desync = 1'b1;
                end
                first_found_nxt = 1'b0;
              end
              // full pulse: width check and midpoint on the stored edges
              if (val >= VAL_SYNCED) begin
                width = $signed({2'b00, second_pos_nxt}) - $signed({2'b00, first_pos_nxt});
                if ((width >= wmin) && (width <= wmax)) begin
                  val       = VAL_VALID;
                  found_nxt = 1'b1;
                end else begin
                  diag_set[DIAG_WIDTH] = 1'b1;
                  desync = 1'b1;
                end
                mid_sum = {1'b0, first_pos_nxt} + {1'b0, second_pos_nxt};
                mid     = mid_sum[POS_W:1];
                if (phase_synced_r) begin
                  if (odd_rev_r != item.rev_odd) begin
                    diag_set[DIAG_EXTRA] = 1'b1;
                    desync = 1'b1;
                  end
                end else begin
                  odd_rev_nxt      = item.rev_odd;
                  phase_synced_nxt = 1'b1;
                end
              end
            end else begin
              desync = 1'b1;
            end
          end else begin
            if (crank_synced_r) begin
              diag_set[DIAG_BAD_PULSE] = 1'b1;
            end
            first_found_nxt = 1'b0;
            desync = 1'b1;
          end
          if (desync && cfg.desync_err && (val > VAL_DETECTED)) begin
            val = VAL_DETECTED;
          end
          held_val_nxt = val;
          held_pos_nxt = mid;
        end
        prev_idx_nxt = idx;
        next_idx_nxt = ~idx[0];
      end else begin
        if (!item.crank_valid) begin
          clean = 1'b1;
        end else begin
          if (first_found_r) begin
            if (!item.in_window) begin
              first_found_nxt = 1'b0;
              if (crank_synced_r) begin
                diag_set[DIAG_BAD_PULSE] = 1'b1;
              end
            end
          end else if (phase_synced_r) begin
            if (!found_r) begin
              if ((odd_rev_r == item.rev_odd) && item.above_max && crank_synced_r) begin
                diag_set[DIAG_LOST] = 1'b1;
                clean = 1'b1;
              end
            end else if (odd_rev_r != item.rev_odd) begin
              found_nxt = 1'b0;
            end
          end else if (item.rev_ge2 && item.above_max) begin
            diag_set[DIAG_NONE] = 1'b1;
            clean = 1'b1;
          end
          if (!crank_synced_r && item.wrap) begin
            crank_synced_nxt = 1'b1;
          end
        end
        // crank invalid, lost or missing signal: drop all pulse tracking, keep level history
        if (clean) begin
          first_pos_nxt    = '0;
          second_pos_nxt   = '0;
          first_found_nxt  = 1'b0;
          phase_synced_nxt = 1'b0;
          odd_rev_nxt      = 1'b0;
          crank_synced_nxt = 1'b0;
          found_nxt        = 1'b0;
          held_val_nxt     = VAL_NONE;
          held_pos_nxt     = '0;
        end
      end
    end

    diag_nxt = diag_r | diag_set;

    out_data_nxt.cam_validity = held_val_nxt;
    out_data_nxt.cam_position = held_pos_nxt;
    out_data_nxt.diag_flags   = diag_nxt;

    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_idx_r     <= 2'd3;
      next_idx_r     <= 1'b0;
      first_pos_r    <= '0;
      second_pos_r   <= '0;
      first_found_r  <= 1'b0;
      phase_synced_r <= 1'b0;
      odd_rev_r      <= 1'b0;
      crank_synced_r <= 1'b0;
      found_r        <= 1'b0;
      held_val_r     <= VAL_NONE;
      held_pos_r     <= '0;
      diag_r         <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      prev_idx_r     <= prev_idx_nxt;
      next_idx_r     <= next_idx_nxt;
      first_pos_r    <= first_pos_nxt;
      second_pos_r   <= second_pos_nxt;
      first_found_r  <= first_found_nxt;
      phase_synced_r <= phase_synced_nxt;
      odd_rev_r      <= odd_rev_nxt;
      crank_synced_r <= crank_synced_nxt;
      found_r        <= found_nxt;
      held_val_r     <= held_val_nxt;
      held_pos_r     <= held_pos_nxt;
      diag_r         <= diag_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

>>> design/cam_single_pulse_sync_top.sv
// Channel | Ports                          | Moves
// --------+--------------------------------+--------------------------------------------
// input   | in_valid, in_ready, in_data    | one cam edge or crank update per transfer
// result  | out_valid, out_ready, out_data | validity, midpoint, sticky diag flags
// config  | cfg_we, cfg_index, cfg_data    | one register write per cycle, no read-back
//
// One result per input transfer, one transfer per cycle sustained while the result
// side takes results. An item is classified on entry, waits in a short queue and
// is executed by the state unit, whose result is held in an output register.
// Synchronous active-low reset clears tracking state and diag flags and returns
// config to its reset values. A stalled result stops the state unit; input keeps
// flowing until the queue is full.
module cam_single_pulse_sync_top import csps_pkg::*; #(
  parameter int QUEUE_DEPTH = CSPS_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  csps_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output csps_out_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  csps_cfg_t  cfg_r, cfg_nxt;
  csps_item_t front_item;
  csps_item_t queue_item;
  logic       queue_valid;
  logic       queue_ready;

  // config register file; the user must write it only while nothing is in flight (not enforced here)
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_ACTIVE_LOW: cfg_nxt.active_low      = cfg_data[0];
        CFG_WIN_MIN:    cfg_nxt.edge_window_min = cfg_data[POS_W-1:0];
        CFG_WIN_MAX:    cfg_nxt.edge_window_max = cfg_data[POS_W-1:0];
        CFG_WIDTH_MIN:  cfg_nxt.width_min       = cfg_data[WID_W-1:0];
        CFG_WIDTH_MAX:  cfg_nxt.width_max       = cfg_data[WID_W-1:0];
        CFG_DESYNC_ERR: cfg_nxt.desync_err      = cfg_data[0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.active_low      <= 1'b0;
      cfg_r.edge_window_min <= '0;
      cfg_r.edge_window_max <= WIN_MAX_RST;
      cfg_r.width_min       <= '0;
      cfg_r.width_max       <= WIDTH_MAX_RST;
      cfg_r.desync_err      <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front: level decode and crank-window compares
  csps_front u_front (
    .in_data (in_data),
    .cfg     (cfg_r),
    .item    (front_item)
  );

  csps_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_data  (front_item),
    .pop_valid  (queue_valid),
    .pop_ready  (queue_ready),
    .pop_data   (queue_item)
  );

  // back: pulse tracking state and registered result
  csps_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_valid (queue_valid),
    .item_ready (queue_ready),
    .item       (queue_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

>>> dv/cam_single_pulse_sync_top_tb.sv
`timescale 1ns / 1ps

module cam_single_pulse_sync_top_tb;
  import csps_pkg::*;

  localparam int MAX_POS       = 23039;  // top of the crank angle range, 1/64 degree
  localparam int REVS_NO_SIGNAL = 2;     // revolutions without a pulse before "no signal"
  localparam int MAX_REPORTS   = 100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_ready;
  csps_in_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  csps_out_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_ACTIVE_LOW;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  cam_single_pulse_sync_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Pending cam/crank events and the cam status each accepted one should give
  // ---------------------------------------------------------------------------
  csps_in_t  cam_crank_q[$];
  csps_out_t status_q[$];

  int send_idle_pct = 0;   // chance per cycle that the sender holds back
  int recv_stall_pct = 0;  // chance per cycle that the result side stalls
  int errors = 0;
  int events_sent = 0;
  int status_checked = 0;
  int settings_used = 0;
  logic [DIAG_W-1:0] diag_seen = '0;
  logic [3:0]        validity_seen = '0;

  // Register copies, as the block holds them
  logic                    cfg_active_low;
  logic [POS_W-1:0]        cfg_win_lo;
  logic [POS_W-1:0]        cfg_win_hi;
  logic signed [WID_W-1:0] cfg_wid_lo;
  logic signed [WID_W-1:0] cfg_wid_hi;
  logic                    cfg_desync;

  // Synchronizer tracking state
  logic [LVL_W-1:0]  last_lvl;      // 3 until a level has been seen
  logic              want_lvl;      // level index an undefined input stands for
  logic [POS_W-1:0]  edge_a_pos;
  logic [POS_W-1:0]  edge_b_pos;
  logic              edge_a_seen;
  logic              rev_locked;    // cam phase tied to a revolution parity
  logic              rev_parity;
  logic              crank_locked;
  logic              pulse_seen;    // pulse found on the current cam cycle
  logic [VAL_W-1:0]  hold_val;
  logic [POS_W-1:0]  hold_mid;
  logic [DIAG_W-1:0] diag_bits;

  // Stimulus generator: crank revolution counter and the revolution parity
  // on which the cam pulse normally falls
  logic [REV_W-1:0] crank_rev = '0;
  logic             pulse_parity = 1'b0;

  // Crank invalid, signal lost or no signal: drop edge, phase and sync state.
  // Level tracking and diag flags survive.
  function automatic void drop_tracking();
    edge_a_pos   = '0;
    edge_b_pos   = '0;
    edge_a_seen  = 1'b0;
    rev_locked   = 1'b0;
    rev_parity   = 1'b0;
    crank_locked = 1'b0;
    pulse_seen   = 1'b0;
    hold_val     = VAL_NONE;
    hold_mid     = '0;
  endfunction

  // Advance the tracking state by one event and give the status it leaves
  function automatic csps_out_t advance_cam_sync(input csps_in_t it);
    logic [LVL_W-1:0] idx;
    logic             undef;
    logic             expect_hi;
    logic             desync;
    logic             clean;
    logic [VAL_W-1:0] val;
    logic [POS_W-1:0] mid;
    logic [POS_W:0]   sum;
    int               w;
    csps_out_t        res;

    val    = hold_val;
    mid    = hold_mid;
    desync = 1'b0;
    clean  = 1'b0;
    if (it.cmd == CMD_EDGE) begin
      undef = (it.pin_level != LVL_LOW) && (it.pin_level != LVL_HIGH);
      if (it.pin_level == LVL_LOW) begin
        idx = LVL_LOW;
      end else if (it.pin_level == LVL_HIGH) begin
        idx = LVL_HIGH;
      end else begin
        idx = {1'b0, want_lvl};
      end
      if (idx == last_lvl) begin
        // repeated level: flag only, held status untouched
        diag_bits[DIAG_SEQUENCE] = 1'b1;
      end else begin
        expect_hi = edge_a_seen ? cfg_active_low : !cfg_active_low;
        if (undef || it.pin_level == {1'b0, expect_hi}) begin
          if (it.crank_error) begin
            diag_bits[DIAG_CRANK_ERR] = 1'b1;
            desync = 1'b1;
          end
          if (it.crank_valid) begin
            if (it.crank_position >= cfg_win_lo && it.crank_position <= cfg_win_hi) begin
              if (!edge_a_seen) begin
                val = VAL_DETECTED;
                edge_a_pos = it.crank_position;
                edge_a_seen = 1'b1;
              end else begin
                edge_a_seen = 1'b0;
                val = VAL_SYNCED;
                edge_b_pos = it.crank_position;
                crank_locked = 1'b1;
              end
            end else begin
              if (crank_locked) begin
                diag_bits[DIAG_WRONG] = 1'b1;
                desync = 1'b1;
              end
              edge_a_seen = 1'b0;
            end
            // a stale synced status is re-judged against the stored edges
            if (val >= VAL_SYNCED) begin
              w = int'(edge_b_pos) - int'(edge_a_pos);
              if (w >= int'(cfg_wid_lo) && w <= int'(cfg_wid_hi)) begin
                val = VAL_VALID;
                pulse_seen = 1'b1;
              end else begin
                diag_bits[DIAG_WIDTH] = 1'b1;
                desync = 1'b1;
              end
              sum = {1'b0, edge_a_pos} + {1'b0, edge_b_pos};
              mid = sum[POS_W:1];
              if (rev_locked) begin
                if (rev_parity != it.revolutions[0]) begin
                  diag_bits[DIAG_EXTRA] = 1'b1;
                  desync = 1'b1;
                end
              end else begin
                rev_parity = it.revolutions[0];
                rev_locked = 1'b1;
              end
            end
          end else begin
            desync = 1'b1;
          end
        end else begin
          if (crank_locked) diag_bits[DIAG_BAD_PULSE] = 1'b1;
          edge_a_seen = 1'b0;
          desync = 1'b1;
        end
        if (desync && cfg_desync && val > VAL_DETECTED) val = VAL_DETECTED;
        hold_val = val;
        hold_mid = mid;
      end
      last_lvl = idx;
      want_lvl = !idx[0];
    end else begin
      if (!it.crank_valid) begin
        clean = 1'b1;
      end else begin
        if (edge_a_seen) begin
          if (it.crank_position > cfg_win_hi || it.crank_position < cfg_win_lo) begin
            edge_a_seen = 1'b0;
            if (crank_locked) diag_bits[DIAG_BAD_PULSE] = 1'b1;
          end
        end else if (rev_locked) begin
          if (!pulse_seen) begin
            if (rev_parity == it.revolutions[0] && it.crank_position > cfg_win_hi &&
                crank_locked) begin
              diag_bits[DIAG_LOST] = 1'b1;
              clean = 1'b1;
            end
          end else if (rev_parity != it.revolutions[0]) begin
            pulse_seen = 1'b0;
          end
        end else if (int'(it.revolutions) >= REVS_NO_SIGNAL &&
                     it.crank_position > cfg_win_hi) begin
          diag_bits[DIAG_NONE] = 1'b1;
          clean = 1'b1;
        end
        // first crank wrap marks the crank as synced
        if (!crank_locked && it.crank_position < it.crank_prev_position) crank_locked = 1'b1;
      end
      if (clean) drop_tracking();
    end
    res.cam_validity = hold_val;
    res.cam_position = hold_mid;
    res.diag_flags   = diag_bits;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents queued events; the status is predicted at each transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        status_q.push_back(advance_cam_sync(in_data));
        events_sent++;
      end
      // valid stays up with the same payload until the transfer happens
      if (!in_valid || in_ready) begin
        if (cam_crank_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= cam_crank_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks every status transfer against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    csps_out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (status_q.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: status with nothing outstanding, got %h", $time, out_data);
        end else begin
          want = status_q.pop_front();
          status_checked++;
          diag_seen |= out_data.diag_flags;
          validity_seen[out_data.cam_validity] = 1'b1;
          if (out_data.cam_validity !== want.cam_validity) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: cam_validity expected %0d got %0d", $time,
                       want.cam_validity, out_data.cam_validity);
          end
          if (out_data.cam_position !== want.cam_position) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: cam_position expected %0d got %0d", $time,
                       want.cam_position, out_data.cam_position);
          end
          if (out_data.diag_flags !== want.diag_flags) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: diag_flags expected %b got %b", $time,
                       want.diag_flags, out_data.diag_flags);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic csps_in_t mk_edge(input logic [LVL_W-1:0] lvl, input logic cv,
                                       input logic ce, input int pos, input logic [REV_W-1:0] rev);
    csps_in_t it;
    it.cmd                 = CMD_EDGE;
    it.pin_level           = lvl;
    it.crank_valid         = cv;
    it.crank_error         = ce;
    it.crank_position      = POS_W'(pos);
    it.crank_prev_position = POS_W'($urandom_range(0, MAX_POS));  // unused on edges
    it.revolutions         = rev;
    return it;
  endfunction

  function automatic csps_in_t mk_crank(input logic cv, input int pos, input int prev,
                                        input logic [REV_W-1:0] rev);
    csps_in_t it;
    it.cmd                 = CMD_CRANK;
    it.pin_level           = LVL_W'($urandom_range(0, 3));  // unused on crank updates
    it.crank_valid         = cv;
    it.crank_error         = 1'($urandom_range(1));
    it.crank_position      = POS_W'(pos);
    it.crank_prev_position = POS_W'(prev);
    it.revolutions         = rev;
    return it;
  endfunction

  // Mostly the intended level; sometimes undefined, sometimes the wrong one
  function automatic logic [LVL_W-1:0] pick_level(input logic [LVL_W-1:0] lvl);
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) return LVL_W'($urandom_range(2, 3));
    if (roll < 12) return (lvl == LVL_HIGH) ? LVL_LOW : LVL_HIGH;
    return lvl;
  endfunction

  // Noise: every field random; positions mostly within the crank range, sometimes over the full width
  function automatic csps_in_t random_event();
    csps_in_t it;
    int       top;
    top = ($urandom_range(3) == 0) ? (1 << POS_W) - 1 : MAX_POS;
    it.cmd                 = 1'($urandom_range(1));
    it.pin_level           = LVL_W'($urandom_range(0, 3));
    it.crank_valid         = 1'($urandom_range(1));
    it.crank_error         = 1'($urandom_range(1));
    it.crank_position      = POS_W'($urandom_range(0, top));
    it.crank_prev_position = POS_W'($urandom_range(0, top));
    it.revolutions         = REV_W'($urandom);
    return it;
  endfunction

  // Revolution-by-revolution traffic: crank updates, a cam pulse on every
  // other revolution (sometimes missing or misplaced), a late update past the
  // window and a wrap. A few events are pure noise.
  task automatic gen_traffic(input int n);
    int               made;
    int               lo;
    int               hi;
    int               a;
    int               b;
    logic [LVL_W-1:0] lead;
    logic [LVL_W-1:0] trail;
    logic             pulse_here;
    made = 0;
    while (made < n) begin
      if (cfg_win_lo <= cfg_win_hi) begin
        lo = int'(cfg_win_lo);
        hi = int'(cfg_win_hi);
      end else begin
        lo = 0;
        hi = MAX_POS;
      end
      if ($urandom_range(99) < 8) begin
        cam_crank_q.push_back(random_event());
        made++;
      end else begin
        repeat ($urandom_range(1, 3)) begin
          a = $urandom_range(0, hi);
          cam_crank_q.push_back(mk_crank($urandom_range(99) >= 3, a,
                                         $urandom_range(0, a), crank_rev));
          made++;
        end
        pulse_here = (crank_rev[0] == pulse_parity) ? ($urandom_range(99) >= 8)
                                                    : ($urandom_range(99) < 8);
        if (pulse_here) begin
          lead  = cfg_active_low ? LVL_LOW : LVL_HIGH;
          trail = cfg_active_low ? LVL_HIGH : LVL_LOW;
          a = $urandom_range(lo, hi);
          if ($urandom_range(99) < 85) begin
            b = a + $urandom_range(0, 3000);
            if (b > hi) b = hi;
          end else begin
            b = $urandom_range(0, MAX_POS);
          end
          cam_crank_q.push_back(mk_edge(pick_level(lead), $urandom_range(99) >= 3,
                                        $urandom_range(99) < 5, a, crank_rev));
          made++;
          if ($urandom_range(99) < 30) begin
            cam_crank_q.push_back(mk_crank(1'b1, a, a, crank_rev));
            made++;
          end
          cam_crank_q.push_back(mk_edge(pick_level(trail), $urandom_range(99) >= 3,
                                        $urandom_range(99) < 5, b, crank_rev));
          made++;
        end
        // late crank update past the window, then wrap into the next revolution
        a = (hi < MAX_POS) ? $urandom_range(hi + 1, MAX_POS) : MAX_POS;
        cam_crank_q.push_back(mk_crank($urandom_range(99) >= 3, a, hi, crank_rev));
        if (crank_rev != '1) crank_rev++;
        cam_crank_q.push_back(mk_crank(1'b1, $urandom_range(0, 300),
                                       $urandom_range(22000, MAX_POS), crank_rev));
        made += 2;
      end
    end
  endtask

  // Sender holds back until every predicted status has been checked
  task automatic wait_drained();
    while (cam_crank_q.size() != 0 || in_valid || status_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_ACTIVE_LOW: cfg_active_low = val[0];
      CFG_WIN_MIN:    cfg_win_lo     = val[POS_W-1:0];
      CFG_WIN_MAX:    cfg_win_hi     = val[POS_W-1:0];
      CFG_WIDTH_MIN:  cfg_wid_lo     = val;
      CFG_WIDTH_MAX:  cfg_wid_hi     = val;
      CFG_DESYNC_ERR: cfg_desync     = val[0];
      default: ;
    endcase
  endtask

  // Only called with the block idle; also restarts the revolution counter
  task automatic apply_setting(input logic al, input int lo, input int hi,
                               input int wlo, input int whi, input logic ds);
    write_reg(CFG_ACTIVE_LOW, CFG_DATA_W'(al));
    write_reg(CFG_WIN_MIN,    CFG_DATA_W'(lo));
    write_reg(CFG_WIN_MAX,    CFG_DATA_W'(hi));
    write_reg(CFG_WIDTH_MIN,  CFG_DATA_W'(wlo));
    write_reg(CFG_WIDTH_MAX,  CFG_DATA_W'(whi));
    write_reg(CFG_DESYNC_ERR, CFG_DATA_W'(ds));
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
    crank_rev    = ($urandom_range(9) == 0) ? REV_W'(65530) : REV_W'($urandom_range(0, 3));
    pulse_parity = 1'($urandom_range(1));
  endtask

  task automatic apply_random_setting();
    int wlo;
    int whi;
    wlo = ($urandom_range(99) < 80) ? $urandom_range(0, 400) : -$urandom_range(0, MAX_POS);
    whi = ($urandom_range(99) < 90) ? $urandom_range(1500, 12000) : MAX_POS;
    apply_setting(1'($urandom_range(1)), $urandom_range(0, 8000),
                  $urandom_range(12000, MAX_POS), wlo, whi, 1'($urandom_range(1)));
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    // register reset values
    cfg_active_low = 1'b0;
    cfg_win_lo     = '0;
    cfg_win_hi     = WIN_MAX_RST;
    cfg_wid_lo     = '0;
    cfg_wid_hi     = WIDTH_MAX_RST;
    cfg_desync     = 1'b1;
    last_lvl       = 2'd3;
    want_lvl       = 1'b0;
    diag_bits      = '0;
    drop_tracking();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: default registers, no idling. Walks every diag flag.
    apply_setting(1'b0, 0, MAX_POS, 0, MAX_POS, 1'b1);
    cam_crank_q.push_back(mk_edge(LVL_HIGH, 1'b1, 1'b0, 0, 16'd0));       // first edge
    cam_crank_q.push_back(mk_edge(LVL_LOW, 1'b1, 1'b0, MAX_POS, 16'd0));  // widest pulse
    cam_crank_q.push_back(mk_edge(LVL_LOW, 1'b1, 1'b0, 100, 16'd0));      // repeated level
    cam_crank_q.push_back(mk_edge(LVL_HIGH, 1'b1, 1'b1, 500, 16'd1));     // crank request failed
    cam_crank_q.push_back(mk_edge(2'd2, 1'b1, 1'b0, 400, 16'd1));         // undefined, neg width
    cam_crank_q.push_back(mk_edge(2'd3, 1'b0, 1'b0, 5, 16'd1));           // unused code, no crank
    cam_crank_q.push_back(mk_edge(LVL_LOW, 1'b1, 1'b0, 50, 16'd1));       // wrong polarity
    cam_crank_q.push_back(mk_crank(1'b1, 32767, 0, 16'hFFFF));            // parity flips
    cam_crank_q.push_back(mk_crank(1'b1, 32767, 100, 16'd2));             // pulse lost
    cam_crank_q.push_back(mk_crank(1'b0, 0, 0, 16'd0));                   // crank invalid
    cam_crank_q.push_back(mk_crank(1'b1, 100, MAX_POS, 16'd0));           // first wrap
    cam_crank_q.push_back(mk_crank(1'b1, 32767, 0, 16'd3));               // no signal
    cam_crank_q.push_back(mk_edge(LVL_HIGH, 1'b1, 1'b0, 1000, 16'd4));
    cam_crank_q.push_back(mk_crank(1'b1, 25000, 1000, 16'd4));            // edge times out
    cam_crank_q.push_back(mk_edge(LVL_LOW, 1'b1, 1'b0, 1200, 16'd4));
    cam_crank_q.push_back(mk_crank(1'b1, 10, 23000, 16'd5));
    cam_crank_q.push_back(mk_edge(LVL_HIGH, 1'b1, 1'b0, 2000, 16'd6));
    cam_crank_q.push_back(mk_edge(LVL_LOW, 1'b1, 1'b0, 2600, 16'd6));     // valid pulse
    cam_crank_q.push_back(mk_edge(LVL_HIGH, 1'b1, 1'b0, 30000, 16'd6));   // outside window
    cam_crank_q.push_back(mk_edge(LVL_LOW, 1'b1, 1'b0, 0, 16'd0));        // bad pulse
    cam_crank_q.push_back(mk_edge(LVL_HIGH, 1'b1, 1'b0, 7000, 16'd7));    // next pulse, odd rev
    cam_crank_q.push_back(mk_edge(LVL_LOW, 1'b1, 1'b0, 7400, 16'd7));     // extra signal
    wait_drained();

    // Random config, full speed
    apply_random_setting();
    gen_traffic(130);
    wait_drained();

    // Active low, widest window and width limits, no desync; sender idles
    send_idle_pct = 75;
    apply_setting(1'b1, 0, MAX_POS, -MAX_POS, MAX_POS, 1'b0);
    gen_traffic(130);
    wait_drained();

    // Receiver stalls; sender pauses halfway until everything is back
    send_idle_pct  = 0;
    recv_stall_pct = 75;
    apply_random_setting();
    gen_traffic(60);
    wait_drained();
    gen_traffic(70);
    wait_drained();

    // Inverted window and inverted width limits
    send_idle_pct  = 8;
    recv_stall_pct = 8;
    apply_setting(1'b0, MAX_POS, 0, MAX_POS, -MAX_POS, 1'b1);
    gen_traffic(40);
    wait_drained();

    apply_random_setting();
    gen_traffic(120);
    wait_drained();

    // allow any stray result to surface
    repeat (10) @(posedge clk);
    if (status_q.size() != 0) begin
      errors++;
      $display("%0t: %0d statuses never arrived", $time, status_q.size());
    end

    $display("%0d cam/crank events over %0d register settings, %0d statuses checked",
             events_sent, settings_used, status_checked);
    $display("diag flags raised: %b, validity levels observed: %b", diag_seen, validity_seen);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #1000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
